// ===== rtl/tff_pkg.sv =====
// Shared types and constants for the TCP/IPv4 frame filter.
// No dependencies; used by every module of the block.
package tff_pkg;

    localparam int unsigned CFG_DATA_W  = 32;
    localparam int unsigned CFG_INDEX_W = 3;
    localparam int unsigned POS_W       = 17;

    localparam logic [CFG_INDEX_W-1:0] CFG_IFACE_ON  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_IFACE     = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_ADDR_ON   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_ADDR      = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_PORT_ON   = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_PORT      = 3'd5;

    localparam logic [POS_W-1:0] POS_MAX          = 17'h1FFFF;
    localparam logic [POS_W-1:0] NET_START_PLAIN  = 17'd14;
    localparam logic [POS_W-1:0] NET_START_TAGGED = 17'd18;
    localparam logic [POS_W-1:0] MAX_KEEP         = 17'd65535;

    localparam logic [15:0] ETYPE_VLAN  = 16'h8100;
    localparam logic [15:0] ETYPE_QINQ  = 16'h88A8;
    localparam logic [15:0] ETYPE_IPV4  = 16'h0800;
    localparam logic [3:0]  IP_VERSION4 = 4'd4;
    localparam logic [3:0]  MIN_HDR_WORDS = 4'd5;
    localparam logic [7:0]  IP_PROTO_TCP  = 8'd6;

    typedef struct packed {
        logic        iface_on;
        logic [31:0] iface;
        logic        addr_on;
        logic [31:0] addr;
        logic        port_on;
        logic [15:0] port;
    } tff_cfg_t;

    typedef struct packed {
        logic [7:0]  frame_byte;
        logic        frame_end;
        logic [31:0] egress_interface;
        logic [31:0] ingress_interface;
    } tff_item_t;

endpackage

// ===== rtl/tff_cfg_regs.sv =====
// Configuration register file of the frame filter.
// Depends on tff_pkg for register indexes and the configuration struct.
module tff_cfg_regs
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_write_enable,
    input  logic [tff_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [tff_pkg::CFG_DATA_W-1:0]   cfg_data,
    output tff_pkg::tff_cfg_t                cfg
);

    tff_pkg::tff_cfg_t cfg_reg;
    tff_pkg::tff_cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write_enable)
        begin
            unique case (cfg_index)
                tff_pkg::CFG_IFACE_ON: cfg_next.iface_on = cfg_data[0];
                tff_pkg::CFG_IFACE:    cfg_next.iface    = cfg_data;
                tff_pkg::CFG_ADDR_ON:  cfg_next.addr_on  = cfg_data[0];
                tff_pkg::CFG_ADDR:     cfg_next.addr     = cfg_data;
                tff_pkg::CFG_PORT_ON:  cfg_next.port_on  = cfg_data[0];
                tff_pkg::CFG_PORT:     cfg_next.port     = cfg_data[15:0];
                default:               cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== rtl/tff_parser.sv =====
// Per-frame header parser and keep decision of the frame filter.
// Depends on tff_pkg; one registered item is consumed per step.
module tff_parser
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               step,
    input  tff_pkg::tff_item_t item,
    input  tff_pkg::tff_cfg_t  cfg,
    output logic               result_valid,
    output logic [15:0]        keep_length
);

    logic [tff_pkg::POS_W-1:0] pos_reg, pos_next;
    logic        vlan_reg, vlan_next;
    logic [15:0] type_reg, type_next;
    logic [3:0]  ihl_reg, ihl_next;
    logic [15:0] iplen_reg, iplen_next;
    logic [3:0]  thl_reg, thl_next;
    logic [31:0] fshift_reg, fshift_next;
    logic        rej_reg, rej_next;
    logic        hc_reg, hc_next;
    logic [1:0]  match_reg, match_next;

    logic [tff_pkg::POS_W-1:0] p, ns, r, t, hdr;
    logic [6:0]  hdr_sum;
    logic [7:0]  b;
    logic        keep;

    always_comb
    begin
        pos_next     = pos_reg;
        vlan_next    = vlan_reg;
        type_next    = type_reg;
        ihl_next     = ihl_reg;
        iplen_next   = iplen_reg;
        thl_next     = thl_reg;
        fshift_next  = fshift_reg;
        rej_next     = rej_reg;
        hc_next      = hc_reg;
        match_next   = match_reg;
        p            = pos_reg;
        b            = item.frame_byte;
        ns           = tff_pkg::NET_START_PLAIN;
        r            = '0;
        t            = '0;
        hdr          = {11'd0, ihl_reg, 2'b00};
        hdr_sum      = '0;
        keep         = 1'b0;
        result_valid = 1'b0;
        keep_length  = '0;

        if (step)
        begin
            if (!rej_reg && !hc_reg)
            begin
                if (p == 17'd12 || p == 17'd13 || (vlan_reg && (p == 17'd16 || p == 17'd17)))
                begin
                    type_next = {type_reg[7:0], b};
                end
                if (p == 17'd13)
                begin
                    if (type_next == tff_pkg::ETYPE_VLAN || type_next == tff_pkg::ETYPE_QINQ)
                    begin
                        vlan_next = 1'b1;
                    end
                    else if (type_next != tff_pkg::ETYPE_IPV4)
                    begin
                        rej_next = 1'b1;
                    end
                end
                else if (p == 17'd17 && vlan_reg)
                begin
                    if (type_next != tff_pkg::ETYPE_IPV4)
                    begin
                        rej_next = 1'b1;
                    end
                end

                ns = vlan_next ? tff_pkg::NET_START_TAGGED : tff_pkg::NET_START_PLAIN;
                if (!rej_next && p >= ns)
                begin
                    r = p - ns;
                    if (r == '0)
                    begin
                        if (b[7:4] != tff_pkg::IP_VERSION4 || b[3:0] < tff_pkg::MIN_HDR_WORDS)
                        begin
                            rej_next = 1'b1;
                        end
                        else
                        begin
                            ihl_next = b[3:0];
                        end
                    end
                    else if (r < hdr)
                    begin
                        if (r == 17'd2 || r == 17'd3)
                        begin
                            iplen_next = {iplen_reg[7:0], b};
                        end
                        if (r == 17'd9 && b != tff_pkg::IP_PROTO_TCP)
                        begin
                            rej_next = 1'b1;
                        end
                        if (r >= 17'd12 && r < 17'd20)
                        begin
                            fshift_next = {fshift_reg[23:0], b};
                            if ((r == 17'd15 || r == 17'd19) && fshift_next == cfg.addr)
                            begin
                                match_next[0] = 1'b1;
                            end
                        end
                    end
                    else
                    begin
                        t = r - hdr;
                        if (t < 17'd4)
                        begin
                            fshift_next = {fshift_reg[23:0], b};
                            if ((t == 17'd1 || t == 17'd3) && fshift_next[15:0] == cfg.port)
                            begin
                                match_next[1] = 1'b1;
                            end
                        end
                        if (t == 17'd12)
                        begin
                            thl_next = b[7:4];
                            if (b[7:4] < tff_pkg::MIN_HDR_WORDS)
                            begin
                                rej_next = 1'b1;
                            end
                        end
                        if (t == 17'd19 && !rej_next)
                        begin
                            hdr_sum = {({1'b0, ihl_reg} + {1'b0, thl_next}), 2'b00};
                            if (iplen_reg <= {9'd0, hdr_sum})
                            begin
                                rej_next = 1'b1;
                            end
                            else
                            begin
                                hc_next = 1'b1;
                            end
                        end
                    end
                end
            end

            if (pos_reg != tff_pkg::POS_MAX)
            begin
                pos_next = pos_reg + 17'd1;
            end

            if (item.frame_end)
            begin
                keep = !rej_next && hc_next;
                if (cfg.iface_on
                    && (item.egress_interface != '0 || item.ingress_interface != '0)
                    && item.egress_interface != cfg.iface
                    && item.ingress_interface != cfg.iface)
                begin
                    keep = 1'b0;
                end
                if (cfg.addr_on && !match_next[0])
                begin
                    keep = 1'b0;
                end
                if (cfg.port_on && !match_next[1])
                begin
                    keep = 1'b0;
                end
                result_valid = 1'b1;
                if (keep)
                begin
                    keep_length = (pos_next > tff_pkg::MAX_KEEP) ? tff_pkg::MAX_KEEP[15:0]
                                                                 : pos_next[15:0];
                end
                pos_next    = '0;
                vlan_next   = 1'b0;
                type_next   = '0;
                ihl_next    = '0;
                iplen_next  = '0;
                thl_next    = '0;
                fshift_next = '0;
                rej_next    = 1'b0;
                hc_next     = 1'b0;
                match_next  = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= '0;
            vlan_reg   <= 1'b0;
            type_reg   <= '0;
            ihl_reg    <= '0;
            iplen_reg  <= '0;
            thl_reg    <= '0;
            fshift_reg <= '0;
            rej_reg    <= 1'b0;
            hc_reg     <= 1'b0;
            match_reg  <= '0;
        end
        else
        begin
            pos_reg    <= pos_next;
            vlan_reg   <= vlan_next;
            type_reg   <= type_next;
            ihl_reg    <= ihl_next;
            iplen_reg  <= iplen_next;
            thl_reg    <= thl_next;
            fshift_reg <= fshift_next;
            rej_reg    <= rej_next;
            hc_reg     <= hc_next;
            match_reg  <= match_next;
        end
    end

endmodule

// ===== rtl/tcp_ipv4_frame_filter_unit.sv =====
// Top level of the TCP/IPv4 frame filter: input register, output register.
// Depends on tff_pkg, tff_cfg_regs and tff_parser.

// Takes one Ethernet frame byte per transaction and, on the byte marked as the
// frame's last, returns one keep_length: 0 if the frame is dropped, otherwise
// the frame length saturated at 65535. Other bytes return nothing. The block
// accepts one byte per cycle while in_stall is low; each byte passes through an
// input register and the parser's combinational update into the output
// register, and a result waits to enter the output register only while
// out_stall holds the previous result. Configuration is to be written
// only while no frame is in flight.
module tcp_ipv4_frame_filter_unit
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [7:0]                       frame_byte,
    input  logic                             frame_end,
    input  logic [31:0]                      egress_interface,
    input  logic [31:0]                      ingress_interface,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [15:0]                      keep_length,
    input  logic                             cfg_write_enable,
    input  logic [tff_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [tff_pkg::CFG_DATA_W-1:0]   cfg_data
);

    tff_pkg::tff_cfg_t  cfg;
    tff_pkg::tff_item_t item_reg;
    logic               item_valid_reg, item_valid_next;
    logic               out_valid_reg, out_valid_next;
    logic [15:0]        keep_reg;
    logic               out_free, advance, in_take;
    logic               res_valid;
    logic [15:0]        res_keep;

    tff_cfg_regs u_cfg
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_write_enable (cfg_write_enable),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .cfg              (cfg)
    );

    tff_parser u_parser
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (advance),
        .item         (item_reg),
        .cfg          (cfg),
        .result_valid (res_valid),
        .keep_length  (res_keep)
    );

    assign out_free = !out_valid_reg || !out_stall;
    assign advance  = item_valid_reg && out_free;
    assign in_stall = item_valid_reg && !out_free;
    assign in_take  = in_valid && !in_stall;

    always_comb
    begin
        item_valid_next = item_valid_reg;
        if (in_take)
        begin
            item_valid_next = 1'b1;
        end
        else if (advance)
        begin
            item_valid_next = 1'b0;
        end
        out_valid_next = advance ? res_valid : (out_valid_reg && out_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            item_valid_reg <= item_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            item_reg.frame_byte        <= frame_byte;
            item_reg.frame_end         <= frame_end;
            item_reg.egress_interface  <= egress_interface;
            item_reg.ingress_interface <= ingress_interface;
        end
        if (advance && res_valid)
        begin
            keep_reg <= res_keep;
        end
    end

    assign out_valid   = out_valid_reg;
    assign keep_length = keep_reg;

endmodule

// ===== sim/tb.sv =====
// Self-checking testbench for tcp_ipv4_frame_filter_unit: builds Ethernet frames byte by byte,
// predicts each keep length and checks every result transaction in order.
// Depends on tff_pkg and the filter RTL.
module tb;

    localparam int CYCLE_LIMIT = 1000000;

    typedef struct {
        bit          has_tag;
        logic [15:0] outer_type;
        logic [15:0] ether_type;
        logic [7:0]  ver_ihl;
        logic [15:0] ip_len;
        logic [7:0]  proto;
        logic [31:0] src_addr;
        logic [31:0] dst_addr;
        logic [15:0] src_port;
        logic [15:0] dst_port;
        logic [7:0]  doff_byte;
        int          payload;
        int          cut;
        logic [31:0] egress;
        logic [31:0] ingress;
    } frame_spec_t;

    class frame_filter_scoreboard;
        bit          iface_on;
        bit [31:0]   iface;
        bit          addr_on;
        bit [31:0]   addr;
        bit          port_on;
        bit [15:0]   port;

        bit [16:0]   pos;
        bit [16:0]   net_start;
        bit [15:0]   type_sr;
        bit [3:0]    ihl;
        bit [15:0]   ip_len;
        bit [3:0]    doff;
        bit [31:0]   field_sr;
        bit          rejected;
        bit          complete;
        bit [1:0]    matched;

        bit [15:0]   keep_q[$];
        int          errors;

        function new();
            errors = 0;
            clear_frame();
        endfunction

        function void clear_frame();
            pos       = '0;
            net_start = tff_pkg::NET_START_PLAIN;
            type_sr   = '0;
            ihl       = '0;
            ip_len    = '0;
            doff      = '0;
            field_sr  = '0;
            rejected  = 1'b0;
            complete  = 1'b0;
            matched   = '0;
        endfunction

        function void set_register(logic [tff_pkg::CFG_INDEX_W-1:0] idx,
                                   logic [tff_pkg::CFG_DATA_W-1:0] v);
            case (idx)
                tff_pkg::CFG_IFACE_ON: iface_on = v[0];
                tff_pkg::CFG_IFACE:    iface    = v;
                tff_pkg::CFG_ADDR_ON:  addr_on  = v[0];
                tff_pkg::CFG_ADDR:     addr     = v;
                tff_pkg::CFG_PORT_ON:  port_on  = v[0];
                tff_pkg::CFG_PORT:     port     = v[15:0];
                default: ;
            endcase
        endfunction

        function void parse(bit [16:0] p, bit [7:0] b);
            int unsigned r;
            int unsigned hdr;
            int unsigned t;
            if (p == 12 || p == 13
                || (net_start == tff_pkg::NET_START_TAGGED && (p == 16 || p == 17)))
                type_sr = {type_sr[7:0], b};
            if (p == 13)
            begin
                if (type_sr == tff_pkg::ETYPE_VLAN || type_sr == tff_pkg::ETYPE_QINQ)
                    net_start = tff_pkg::NET_START_TAGGED;
                else if (type_sr != tff_pkg::ETYPE_IPV4)
                    rejected = 1'b1;
            end
            else if (p == 17 && net_start == tff_pkg::NET_START_TAGGED)
            begin
                if (type_sr != tff_pkg::ETYPE_IPV4)
                    rejected = 1'b1;
            end
            if (rejected || p < net_start)
                return;
            r = p - net_start;
            if (r == 0)
            begin
                if (b[7:4] != tff_pkg::IP_VERSION4 || b[3:0] < tff_pkg::MIN_HDR_WORDS)
                    rejected = 1'b1;
                else
                    ihl = b[3:0];
                return;
            end
            hdr = ihl * 4;
            if (r < hdr)
            begin
                if (r == 2 || r == 3)
                    ip_len = {ip_len[7:0], b};
                if (r == 9 && b != tff_pkg::IP_PROTO_TCP)
                    rejected = 1'b1;
                if (r >= 12 && r < 20)
                begin
                    field_sr = {field_sr[23:0], b};
                    if ((r == 15 || r == 19) && field_sr == addr)
                        matched[0] = 1'b1;
                end
                return;
            end
            t = r - hdr;
            if (t < 4)
            begin
                field_sr = {field_sr[23:0], b};
                if ((t == 1 || t == 3) && field_sr[15:0] == port)
                    matched[1] = 1'b1;
            end
            if (t == 12)
            begin
                doff = b[7:4];
                if (doff < tff_pkg::MIN_HDR_WORDS)
                    rejected = 1'b1;
            end
            if (t == 19 && !rejected)
            begin
                if (ip_len <= (ihl + doff) * 4)
                    rejected = 1'b1;
                else
                    complete = 1'b1;
            end
        endfunction

        // One accepted input transaction.
        function void note_byte(bit [7:0] b, bit last, bit [31:0] eg, bit [31:0] ing);
            bit        keep;
            bit [16:0] len;
            if (!rejected && !complete)
                parse(pos, b);
            if (pos != tff_pkg::POS_MAX)
                pos++;
            if (!last)
                return;
            keep = !rejected && complete;
            if (iface_on && (eg != 0 || ing != 0) && eg != iface && ing != iface)
                keep = 1'b0;
            if (addr_on && !matched[0])
                keep = 1'b0;
            if (port_on && !matched[1])
                keep = 1'b0;
            len = (pos > tff_pkg::MAX_KEEP) ? tff_pkg::MAX_KEEP : pos;
            keep_q.push_back(keep ? len[15:0] : 16'd0);
            clear_frame();
        endfunction

        // One accepted result transaction.
        function void check_keep(logic [15:0] actual);
            bit [15:0] want;
            if (keep_q.size() == 0)
            begin
                $display("%0t: unexpected keep_length, expected none, got %0d", $time, actual);
                errors++;
                return;
            end
            want = keep_q.pop_front();
            if (actual !== want)
            begin
                $display("%0t: keep_length expected %0d, got %0d", $time, want, actual);
                errors++;
            end
        endfunction
    endclass

    logic                            clk;
    logic                            rst_n;
    logic                            in_valid;
    logic                            in_stall;
    logic [7:0]                      frame_byte;
    logic                            frame_end;
    logic [31:0]                     egress_interface;
    logic [31:0]                     ingress_interface;
    logic                            out_valid;
    logic                            out_stall;
    logic [15:0]                     keep_length;
    logic                            cfg_write_enable;
    logic [tff_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [tff_pkg::CFG_DATA_W-1:0]  cfg_data;

    frame_filter_scoreboard sb = new();

    int     send_idle_pct;
    int     recv_stall_pct;
    int     phase_bytes;
    int     cycle_count = 0;
    logic [7:0] frame_bytes[$];

    tcp_ipv4_frame_filter_unit dut
    (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .frame_byte        (frame_byte),
        .frame_end         (frame_end),
        .egress_interface  (egress_interface),
        .ingress_interface (ingress_interface),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .keep_length       (keep_length),
        .cfg_write_enable  (cfg_write_enable),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            out_stall = ($urandom_range(0, 99) < recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_keep(keep_length);
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic write_register(input logic [tff_pkg::CFG_INDEX_W-1:0] idx,
                                  input logic [tff_pkg::CFG_DATA_W-1:0] data);
        cfg_write_enable = 1'b1;
        cfg_index        = idx;
        cfg_data         = data;
        @(posedge clk);
        sb.set_register(idx, data);
        @(negedge clk);
        cfg_write_enable = 1'b0;
    endtask

    task automatic apply_settings(input bit ion, input logic [31:0] iface,
                                  input bit aon, input logic [31:0] addr,
                                  input bit pon, input logic [15:0] port);
        write_register(tff_pkg::CFG_IFACE_ON, {31'd0, ion});
        write_register(tff_pkg::CFG_IFACE, iface);
        write_register(tff_pkg::CFG_ADDR_ON, {31'd0, aon});
        write_register(tff_pkg::CFG_ADDR, addr);
        write_register(tff_pkg::CFG_PORT_ON, {31'd0, pon});
        write_register(tff_pkg::CFG_PORT, {16'd0, port});
    endtask

    task automatic wait_for_results();
        in_valid = 1'b0;
        while (sb.keep_q.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic send_byte(input logic [7:0] b, input logic last,
                             input logic [31:0] eg, input logic [31:0] ing, input int idle);
        while ($urandom_range(0, 99) < idle)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid          = 1'b1;
        frame_byte        = b;
        frame_end         = last;
        egress_interface  = eg;
        ingress_interface = ing;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_byte(b, last, eg, ing);
        @(negedge clk);
    endtask

    task automatic send_frame(input frame_spec_t s);
        int idle;
        frame_bytes.delete();
        repeat (12) frame_bytes.push_back(8'($urandom));
        if (s.has_tag)
        begin
            frame_bytes.push_back(s.outer_type[15:8]);
            frame_bytes.push_back(s.outer_type[7:0]);
            repeat (2) frame_bytes.push_back(8'($urandom));
        end
        frame_bytes.push_back(s.ether_type[15:8]);
        frame_bytes.push_back(s.ether_type[7:0]);
        frame_bytes.push_back(s.ver_ihl);
        frame_bytes.push_back(8'($urandom));
        frame_bytes.push_back(s.ip_len[15:8]);
        frame_bytes.push_back(s.ip_len[7:0]);
        repeat (5) frame_bytes.push_back(8'($urandom));
        frame_bytes.push_back(s.proto);
        repeat (2) frame_bytes.push_back(8'($urandom));
        for (int i = 3; i >= 0; i--)
            frame_bytes.push_back(s.src_addr[i*8 +: 8]);
        for (int i = 3; i >= 0; i--)
            frame_bytes.push_back(s.dst_addr[i*8 +: 8]);
        if (s.ver_ihl[3:0] > 5)
            repeat ((s.ver_ihl[3:0] - 5) * 4) frame_bytes.push_back(8'($urandom));
        frame_bytes.push_back(s.src_port[15:8]);
        frame_bytes.push_back(s.src_port[7:0]);
        frame_bytes.push_back(s.dst_port[15:8]);
        frame_bytes.push_back(s.dst_port[7:0]);
        repeat (8) frame_bytes.push_back(8'($urandom));
        frame_bytes.push_back(s.doff_byte);
        repeat (7) frame_bytes.push_back(8'($urandom));
        if (s.doff_byte[7:4] > 5)
            repeat ((s.doff_byte[7:4] - 5) * 4) frame_bytes.push_back(8'($urandom));
        repeat (s.payload) frame_bytes.push_back(8'($urandom));
        if (s.cut > 0)
            while (frame_bytes.size() > s.cut)
                void'(frame_bytes.pop_back());

        // some frames go through back to back
        idle = ($urandom_range(0, 3) == 0) ? 0 : send_idle_pct;
        for (int i = 0; i < frame_bytes.size(); i++)
            send_byte(frame_bytes[i], i == frame_bytes.size() - 1, s.egress, s.ingress, idle);
        phase_bytes += frame_bytes.size();
    endtask

    function automatic frame_spec_t valid_spec();
        frame_spec_t s;
        s.has_tag    = 1'b0;
        s.outer_type = tff_pkg::ETYPE_VLAN;
        s.ether_type = tff_pkg::ETYPE_IPV4;
        s.ver_ihl    = {tff_pkg::IP_VERSION4, tff_pkg::MIN_HDR_WORDS};
        s.ip_len     = 16'd40 + 16'($urandom_range(1, 1460));
        s.proto      = tff_pkg::IP_PROTO_TCP;
        s.src_addr   = $urandom;
        s.dst_addr   = $urandom;
        s.src_port   = 16'($urandom);
        s.dst_port   = 16'($urandom);
        s.doff_byte  = {tff_pkg::MIN_HDR_WORDS, 4'($urandom)};
        s.payload    = $urandom_range(0, 8);
        s.cut        = 0;
        s.egress     = $urandom;
        s.ingress    = $urandom;
        return s;
    endfunction

    function automatic frame_spec_t random_spec();
        frame_spec_t s;
        bit [3:0]    ihl;
        bit [3:0]    doff;
        s    = valid_spec();
        ihl  = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(5, 15))
                                           : tff_pkg::MIN_HDR_WORDS;
        doff = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(5, 15))
                                           : tff_pkg::MIN_HDR_WORDS;
        s.ver_ihl   = {tff_pkg::IP_VERSION4, ihl};
        s.doff_byte = {doff, 4'($urandom)};
        case ($urandom_range(0, 15))
            0:       s.ip_len = 16'((ihl + doff) * 4);
            1:       s.ip_len = 16'($urandom);
            default: s.ip_len = 16'((ihl + doff) * 4 + $urandom_range(1, 200));
        endcase
        case ($urandom_range(0, 2))
            0:       s.has_tag = 1'b0;
            1:       s.has_tag = 1'b1;
            default:
            begin
                s.has_tag    = 1'b1;
                s.outer_type = tff_pkg::ETYPE_QINQ;
            end
        endcase
        case ($urandom_range(0, 3))
            0: s.src_addr = sb.addr;
            1: s.dst_addr = sb.addr;
            default: ;
        endcase
        case ($urandom_range(0, 3))
            0: s.src_port = sb.port;
            1: s.dst_port = sb.port;
            default: ;
        endcase
        case ($urandom_range(0, 3))
            0:
            begin
                s.egress  = '0;
                s.ingress = '0;
            end
            1: s.egress  = sb.iface;
            2: s.ingress = sb.iface;
            default: ;
        endcase
        case ($urandom_range(0, 11))
            0: s.ether_type = 16'($urandom);
            1: s.ver_ihl    = 8'($urandom);
            2: s.proto      = 8'($urandom);
            3: s.doff_byte  = {4'($urandom_range(0, 4)), 4'($urandom)};
            4: s.cut        = $urandom_range(1, 70);
            5:
            begin
                s.has_tag    = 1'b1;
                s.outer_type = 16'($urandom);
            end
            default: ;
        endcase
        s.payload = $urandom_range(0, 12);
        return s;
    endfunction

    initial
    begin
        frame_spec_t s;

        rst_n             = 1'b0;
        in_valid          = 1'b0;
        frame_byte        = '0;
        frame_end         = 1'b0;
        egress_interface  = '0;
        ingress_interface = '0;
        cfg_write_enable  = 1'b0;
        cfg_index         = '0;
        cfg_data          = '0;
        send_idle_pct     = 0;
        recv_stall_pct    = 0;
        phase_bytes       = 0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;

        // header checks with every filter off
        apply_settings(1'b0, '0, 1'b0, '0, 1'b0, '0);
        s = valid_spec(); s.payload = 0; send_frame(s);
        s = valid_spec(); s.has_tag = 1'b1; send_frame(s);
        s = valid_spec(); s.has_tag = 1'b1; s.outer_type = tff_pkg::ETYPE_QINQ; send_frame(s);
        s = valid_spec(); s.ether_type = 16'h86DD; send_frame(s);
        s = valid_spec(); s.has_tag = 1'b1; s.ether_type = 16'h0806; send_frame(s);
        s = valid_spec(); s.ver_ihl = 8'h65; send_frame(s);
        s = valid_spec(); s.ver_ihl = 8'h44; send_frame(s);
        s = valid_spec(); s.proto = 8'd17; send_frame(s);
        s = valid_spec(); s.doff_byte = 8'h4F; send_frame(s);
        s = valid_spec(); s.ip_len = 16'd40; send_frame(s);
        s = valid_spec(); s.ip_len = 16'd41; send_frame(s);
        s = valid_spec(); s.ver_ihl = 8'h4F; s.doff_byte = 8'hF0; s.ip_len = 16'hFFFF;
        send_frame(s);
        s = valid_spec(); s.cut = 53; send_frame(s);
        s = valid_spec(); s.cut = 54; send_frame(s);
        s = valid_spec(); s.cut = 1; send_frame(s);
        wait_for_results();

        // interface check
        apply_settings(1'b1, 32'hA5A5_0001, 1'b0, '0, 1'b0, '0);
        s = valid_spec(); s.egress = '0; s.ingress = '0; send_frame(s);
        s = valid_spec(); s.egress = 32'hA5A5_0001; send_frame(s);
        s = valid_spec(); s.ingress = 32'hA5A5_0001; send_frame(s);
        s = valid_spec(); s.egress = 32'h5A5A_FFFE; s.ingress = 32'h0000_0001; send_frame(s);
        wait_for_results();

        // address and port checks
        apply_settings(1'b0, '0, 1'b1, 32'hC0A8_0001, 1'b1, 16'h1F90);
        s = valid_spec(); s.src_addr = 32'hC0A8_0001; s.src_port = 16'h1F90; send_frame(s);
        s = valid_spec(); s.dst_addr = 32'hC0A8_0001; s.dst_port = 16'h1F90; send_frame(s);
        s = valid_spec(); s.dst_port = 16'h1F90; send_frame(s);
        s = valid_spec(); s.src_addr = 32'hC0A8_0001; send_frame(s);

        for (int ph = 0; ph < 4; ph++)
        begin
            wait_for_results();
            case (ph)
                0:
                begin
                    apply_settings(1'b1, '1, 1'b1, '1, 1'b1, '1);
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    apply_settings(1'b1, '0, 1'b1, '0, 1'b1, '0);
                    send_idle_pct  = 64;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    apply_settings(1'($urandom), $urandom, 1'($urandom), $urandom,
                                   1'($urandom), 16'($urandom));
                    send_idle_pct  = 0;
                    recv_stall_pct = 64;
                end
                default:
                begin
                    apply_settings(1'b0, $urandom, 1'b0, $urandom, 1'b0, 16'($urandom));
                    send_idle_pct  = 11;
                    recv_stall_pct = 11;
                end
            endcase
            phase_bytes = 0;
            while (phase_bytes < 275)
                send_frame(random_spec());
        end

        wait_for_results();
        repeat (8) @(negedge clk);
        if (sb.errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
